[hdl/mfr_pkg.sv]
// shared types and constants for the motor feedback frame receiver
package mfr_pkg;

  localparam int unsigned FeedbackBytes = 9;
  localparam int unsigned ReplyBytes    = 8;
  localparam int unsigned IdxW          = 4;

  localparam logic [7:0]  AddrReset  = 8'h02;
  localparam logic [7:0]  ReplyMark  = 8'h36;
  localparam logic [7:0]  ReplyEnd   = 8'h6B;
  localparam logic [7:0]  NegSign    = 8'h01;
  localparam logic [31:0] AngleNoVal = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_UNKNOWN  = 2'd0,
    KIND_FEEDBACK = 2'd1,
    KIND_REPLY    = 2'd2
  } kind_e;

  // one complete frame as captured by the framer
  typedef struct packed {
    logic                               is_reply;
    logic [FeedbackBytes-1:0][7:0]      bytes;
  } frame_rec_t;

  typedef struct packed {
    logic        frame_kind;
    logic        check_ok;
    logic [7:0]  reach_status;
    logic [15:0] speed_tenths;
    logic [31:0] angle_tenths;
    logic [31:0] position_count;
  } result_t;

endpackage

[hdl/mfr_framer.sv]
// byte framer: address hunt, frame kind detection, byte capture, frame record stage
module mfr_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         device_address_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               rec_valid_o,
  input  logic               rec_ready_i,
  output mfr_pkg::frame_rec_t rec_o
);
  import mfr_pkg::*;

  logic                          in_frame_q, in_frame_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  kind_e                         kind_q, kind_d;
  logic [FeedbackBytes-1:0][7:0] store_q, store_d;
  logic                          rec_valid_q, rec_valid_d;
  frame_rec_t                    rec_q, rec_d;

  logic                          byte_fire;
  logic [IdxW-1:0]               idx_next;
  kind_e                         kind_now;
  logic                          frame_done;
  logic [FeedbackBytes-1:0][7:0] merged;

  assign in_ready_o  = !rec_valid_q || rec_ready_i;
  assign byte_fire   = in_valid_i && in_ready_o;
  assign idx_next    = idx_q + IdxW'(1);
  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

  // frame bytes including the one arriving now
  always_comb begin
    for (int i = 0; i < FeedbackBytes; i++) begin
      merged[i] = (idx_q == IdxW'(i)) ? rx_byte_i : store_q[i];
    end
  end

  always_comb begin
    kind_now = kind_q;
    if (idx_q == IdxW'(1) && kind_q == KIND_UNKNOWN) begin
      kind_now = (rx_byte_i == ReplyMark) ? KIND_REPLY : KIND_FEEDBACK;
    end
    frame_done = in_frame_q &&
                 ((kind_now == KIND_REPLY && idx_next >= IdxW'(ReplyBytes)) ||
                  (kind_now == KIND_FEEDBACK && idx_next >= IdxW'(FeedbackBytes)));
  end

  always_comb begin
    in_frame_d  = in_frame_q;
    idx_d       = idx_q;
    kind_d      = kind_q;
    store_d     = store_q;
    rec_d       = rec_q;
    rec_valid_d = rec_valid_q && !rec_ready_i;
    if (byte_fire) begin
      if (!in_frame_q) begin
        if (rx_byte_i == device_address_i) begin
          store_d[0] = rx_byte_i;
          idx_d      = IdxW'(1);
          kind_d     = KIND_UNKNOWN;
          in_frame_d = 1'b1;
        end
      end else begin
        store_d = merged;
        kind_d  = kind_now;
        if (frame_done) begin
          rec_d.is_reply = (kind_now == KIND_REPLY);
          rec_d.bytes    = merged;
          rec_valid_d    = 1'b1;
          in_frame_d     = 1'b0;
          idx_d          = '0;
        end else begin
          idx_d = idx_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      idx_q       <= '0;
      kind_q      <= KIND_UNKNOWN;
      rec_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      idx_q       <= idx_d;
      kind_q      <= kind_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    rec_q   <= rec_d;
  end

endmodule

[hdl/mfr_decode.sv]
// frame decode: check, field extraction, sign handling
module mfr_decode (
  input  mfr_pkg::frame_rec_t rec_i,
  output mfr_pkg::result_t    res_o
);
  import mfr_pkg::*;

  logic [7:0]  xor_sum;
  logic [31:0] angle;
  logic [31:0] mag;

  always_comb begin
    xor_sum = '0;
    for (int i = 0; i < FeedbackBytes - 1; i++) begin
      xor_sum = xor_sum ^ rec_i.bytes[i];
    end
    angle = {rec_i.bytes[4], rec_i.bytes[5], rec_i.bytes[6], rec_i.bytes[7]};
    mag   = {rec_i.bytes[3], rec_i.bytes[4], rec_i.bytes[5], rec_i.bytes[6]};

    res_o            = '0;
    res_o.frame_kind = rec_i.is_reply;
    if (rec_i.is_reply) begin
      if (rec_i.bytes[ReplyBytes-1] == ReplyEnd) begin
        res_o.check_ok       = 1'b1;
        res_o.position_count = (rec_i.bytes[2] == NegSign) ? (32'd0 - mag) : mag;
      end
    end else if (xor_sum == rec_i.bytes[FeedbackBytes-1]) begin
      res_o.check_ok       = 1'b1;
      res_o.reach_status   = rec_i.bytes[1];
      res_o.speed_tenths   = {rec_i.bytes[2], rec_i.bytes[3]};
      // no-value pattern reads as zero
      res_o.angle_tenths   = (angle == AngleNoVal) ? 32'd0 : angle;
    end
  end

endmodule

[hdl/motor_feedback_frame_receiver.sv]
// motor feedback frame receiver: top level with address register and result register
// a frame is registered in the framer's record stage, then in the result register
// throughput: one byte per cycle; the framer's record stage and the result register
// both advance while the result side is not stalled
// reset: asynchronous active low; clears framing state and valid flags, address to 0x02
module motor_feedback_frame_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_kind_o,
  output logic                check_ok_o,
  output logic [7:0]          reach_status_o,
  output logic [15:0]         speed_tenths_o,
  output logic signed [31:0]  angle_tenths_o,
  output logic signed [31:0]  position_count_o
);
  import mfr_pkg::*;

  logic       [7:0] addr_q;
  logic             rec_valid;
  logic             rec_ready;
  frame_rec_t       rec;
  result_t          res;
  result_t          res_q;
  logic             out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign rec_ready   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= AddrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      addr_q <= cfg_data_i;
    end
  end

  mfr_framer u_framer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .device_address_i (addr_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .rec_valid_o      (rec_valid),
    .rec_ready_i      (rec_ready),
    .rec_o            (rec)
  );

  mfr_decode u_decode (
    .rec_i (rec),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rec_ready) begin
      out_valid_q <= rec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready && rec_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_kind_o     = res_q.frame_kind;
  assign check_ok_o       = res_q.check_ok;
  assign reach_status_o   = res_q.reach_status;
  assign speed_tenths_o   = res_q.speed_tenths;
  assign angle_tenths_o   = res_q.angle_tenths;
  assign position_count_o = res_q.position_count;

endmodule

[hdl/mfr_checker.sv]
// port-level checker for the frame receiver and its bind
module mfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               frame_kind_o,
  input logic               check_ok_o,
  input logic [7:0]         reach_status_o,
  input logic [15:0]        speed_tenths_o,
  input logic signed [31:0] angle_tenths_o,
  input logic signed [31:0] position_count_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_kind_o) &&
      $stable(check_ok_o) && $stable(angle_tenths_o) && $stable(position_count_o))
    else $error("result changed while stalled");

  // failed check clears every field
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !check_ok_o |-> reach_status_o == 8'd0 && speed_tenths_o == 16'd0 &&
      angle_tenths_o == 32'sd0 && position_count_o == 32'sd0)
    else $error("fields not zero on failed check");

  // fields of the other frame kind stay zero
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_kind_o ? (reach_status_o == 8'd0 && speed_tenths_o == 16'd0 &&
      angle_tenths_o == 32'sd0) : (position_count_o == 32'sd0)))
    else $error("field of other frame kind not zero");

  // the no-value angle pattern never leaves the block
  a_angle_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_tenths_o != 32'sh8000_0000)
    else $error("angle no-value pattern on output");

endmodule

bind motor_feedback_frame_receiver mfr_checker u_mfr_checker (.*);

[dv/mfr_frame_checker.sv]
// frame checker: tracks the receiver's framing, predicts each result and compares it
`timescale 1ns / 100ps

module mfr_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               frame_kind_i,
  input  logic               check_ok_i,
  input  logic [7:0]         reach_status_i,
  input  logic [15:0]        speed_tenths_i,
  input  logic [31:0]        angle_tenths_i,
  input  logic [31:0]        position_count_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);
  import mfr_pkg::*;

  logic [7:0]      hunt_addr = AddrReset;
  logic            in_frame  = 1'b0;
  logic [IdxW-1:0] byte_idx  = '0;
  kind_e           kind      = KIND_UNKNOWN;
  logic [7:0]      frame_buf [FeedbackBytes];
  result_t         expected_frames [$];
  result_t         want;
  int unsigned     fails   = 0;
  int unsigned     waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic logic [31:0] word_at(input int unsigned at);
    return {frame_buf[at], frame_buf[at+1], frame_buf[at+2], frame_buf[at+3]};
  endfunction

  // one accepted byte through the framer; a completed frame queues its result
  task automatic decode_byte(input logic [7:0] b);
    result_t     r;
    logic [7:0]  x;
    logic [31:0] w;
    if (!in_frame) begin
      if (b == hunt_addr) begin
        frame_buf[0] = b;
        byte_idx     = IdxW'(1);
        kind         = KIND_UNKNOWN;
        in_frame     = 1'b1;
      end
      return;
    end
    if (byte_idx < FeedbackBytes) frame_buf[byte_idx] = b;
    byte_idx = byte_idx + 1'b1;
    if (byte_idx == 2 && kind == KIND_UNKNOWN) begin
      kind = (b == ReplyMark) ? KIND_REPLY : KIND_FEEDBACK;
    end
    if ((kind == KIND_REPLY && byte_idx >= ReplyBytes) ||
        (kind == KIND_FEEDBACK && byte_idx >= FeedbackBytes)) begin
      r = '0;
      if (kind == KIND_REPLY) begin
        r.frame_kind = 1'b1;
        if (frame_buf[ReplyBytes-1] == ReplyEnd) begin
          w                = word_at(3);
          r.check_ok       = 1'b1;
          // negation wraps, so the most negative magnitude stays as it is
          r.position_count = (frame_buf[2] == NegSign) ? -w : w;
        end
      end else begin
        x = '0;
        for (int i = 0; i < FeedbackBytes - 1; i++) x ^= frame_buf[i];
        if (x == frame_buf[FeedbackBytes-1]) begin
          w                = word_at(4);
          r.check_ok       = 1'b1;
          r.reach_status   = frame_buf[1];
          r.speed_tenths   = {frame_buf[2], frame_buf[3]};
          r.angle_tenths   = (w == AngleNoVal) ? '0 : w;
        end
      end
      expected_frames.push_back(r);
      in_frame = 1'b0;
      byte_idx = '0;
    end
  endtask

  task automatic cmp_field(input string what, input logic [31:0] exp_v,
                           input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_addr = AddrReset;
      in_frame  = 1'b0;
      byte_idx  = '0;
      kind      = KIND_UNKNOWN;
      expected_frames.delete();
    end else begin
      // results leave only after the record and result registers, so check them first
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: result transfer with none expected, expected none actual kind %b",
                   $time, frame_kind_i);
          fails++;
        end else begin
          want = expected_frames.pop_front();
          cmp_field("frame_kind", 32'(want.frame_kind), 32'(frame_kind_i));
          cmp_field("check_ok", 32'(want.check_ok), 32'(check_ok_i));
          cmp_field("reach_status", 32'(want.reach_status), 32'(reach_status_i));
          cmp_field("speed_tenths", 32'(want.speed_tenths), 32'(speed_tenths_i));
          cmp_field("angle_tenths", want.angle_tenths, angle_tenths_i);
          cmp_field("position_count", want.position_count, position_count_i);
        end
      end
      if (in_valid_i && in_ready_i) decode_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_i) hunt_addr = cfg_data_i;
    end
    waiting = expected_frames.size();
  end

endmodule

[dv/tb_top.sv]
// testbench top: clock, reset, byte and frame stimulus, result back-pressure, verdict
`timescale 1ns / 100ps

module tb_top;
  import mfr_pkg::*;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               frame_kind;
  logic               check_ok;
  logic [7:0]         reach_status;
  logic [15:0]        speed_tenths;
  logic signed [31:0] angle_tenths;
  logic signed [31:0] position_count;
  int unsigned        fails;
  int unsigned        pending;

  logic [7:0]         tx_q [$];
  logic [7:0]         cur_addr = AddrReset;
  bit                 steady   = 1'b0;

  motor_feedback_frame_receiver dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .frame_kind_o     (frame_kind),
    .check_ok_o       (check_ok),
    .reach_status_o   (reach_status),
    .speed_tenths_o   (speed_tenths),
    .angle_tenths_o   (angle_tenths),
    .position_count_o (position_count)
  );

  mfr_frame_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .frame_kind_i     (frame_kind),
    .check_ok_i       (check_ok),
    .reach_status_i   (reach_status),
    .speed_tenths_i   (speed_tenths),
    .angle_tenths_i   (angle_tenths),
    .position_count_i (position_count),
    .fail_count_o     (fails),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // payload bytes lean toward the extremes and toward the address value
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return cur_addr;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return AngleNoVal;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_sign();
    case ($urandom_range(0, 3))
      0, 1:    return NegSign;
      2:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_feedback(input logic [7:0] arr, input logic [15:0] spd,
                               input logic [31:0] ang, input bit bad);
    logic [7:0] fb [FeedbackBytes];
    logic [7:0] x;
    fb = '{cur_addr, arr, spd[15:8], spd[7:0],
           ang[31:24], ang[23:16], ang[15:8], ang[7:0], 8'h00};
    x = '0;
    for (int i = 0; i < FeedbackBytes - 1; i++) x ^= fb[i];
    fb[FeedbackBytes-1] = bad ? x ^ 8'($urandom_range(1, 255)) : x;
    foreach (fb[i]) tx_q.push_back(fb[i]);
  endtask

  task automatic push_reply(input logic [7:0] sign, input logic [31:0] mag, input bit bad);
    tx_q.push_back(cur_addr);
    tx_q.push_back(ReplyMark);
    tx_q.push_back(sign);
    for (int i = 3; i >= 0; i--) tx_q.push_back(mag[8*i +: 8]);
    tx_q.push_back(bad ? ReplyEnd ^ 8'($urandom_range(1, 255)) : ReplyEnd);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    rx_byte  <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic flush_tx();
    foreach (tx_q[i]) send_byte(tx_q[i]);
    tx_q.delete();
  endtask

  // hold the byte side until every result is back and the pipeline has emptied
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_addr(input logic [7:0] a);
    cfg_data  <= a;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_addr   = a;
  endtask

  // result side back-pressure: ready runs and stalls, now and then a long stall
  initial begin
    int unsigned run;
    bit          stall;
    forever begin
      stall = ($urandom_range(0, 3) == 0);
      if (stall) begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end else begin
        run = $urandom_range(1, 40);
      end
      out_ready <= !stall;
      repeat (run) @(negedge clk);
    end
  end

  initial begin
    int unsigned frame_bytes;
    int unsigned r;
    logic [7:0]  addr_list [7];
    addr_list = '{AddrReset, 8'h00, 8'hFF, ReplyMark, ReplyEnd, 8'($urandom), AddrReset};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_addr(addr_list[ph]);
      if (ph == 0) begin
        // negative most-negative position; address byte as data with extreme
        // speed and the no-value angle; reply with a broken terminator
        push_reply(NegSign, 32'h8000_0000, 1'b0);
        push_feedback(AddrReset, 16'hFFFF, AngleNoVal, 1'b0);
        push_reply(8'h00, 32'hFFFF_FFFF, 1'b1);
        flush_tx();
      end
      frame_bytes = 0;
      while (frame_bytes < 140) begin
        r      = $urandom_range(0, 99);
        steady = ($urandom_range(0, 3) == 0);
        if (r < 45) begin
          push_feedback(pick_byte(), {pick_byte(), pick_byte()}, pick_word(),
                        $urandom_range(0, 7) == 0);
        end else if (r < 85) begin
          push_reply(pick_sign(), pick_word(), $urandom_range(0, 7) == 0);
        end else if (r < 93) begin
          // truncated frame: the next frame's bytes land inside it
          if (r[0]) push_feedback(pick_byte(), 16'($urandom), $urandom, 1'b0);
          else push_reply(pick_sign(), $urandom, 1'b0);
          tx_q = tx_q[0:$urandom_range(1, 6)];
        end
        if (r < 93) begin
          frame_bytes += tx_q.size();
        end else begin
          repeat ($urandom_range(1, 5)) tx_q.push_back(8'($urandom));
        end
        flush_tx();
      end
      steady = 1'b0;
      drain();
    end

    repeat (10) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
